### src/assert_macros.svh
// Assertion helpers for the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### src/bdsp_pkg.sv
package bdsp_pkg;

  // Trace store geometry
  localparam int TRACE_LEN = 4096;
  localparam int ADDR_W    = $clog2(TRACE_LEN);

  // Field widths
  localparam int IDX_W    = 12;
  localparam int SMP_W    = 16;
  localparam int POS_W    = 12;
  localparam int DEPTH_W  = 12;
  localparam int DX_W     = POS_W + 1;
  localparam int SQ_W     = 2 * POS_W;
  localparam int REM_W    = SQ_W + 1;
  localparam int ROOT_W   = 24;

  // Square root schedule
  localparam int ROOT_START_BIT = 4194304;
  localparam int ROOT_STEPS     = 12;

  // Item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  // Payload carried down the pipeline with each word
  typedef struct packed {
    logic                      cmd;
    logic [IDX_W-1:0]          idx;
    logic signed [SMP_W-1:0]   val;
    logic [DEPTH_W-1:0]        depth;
  } item_t;

  // Trial bit of root step k (1-based)
  function automatic logic [ROOT_W-1:0] root_bit(input int k);
    return ROOT_W'(ROOT_START_BIT >> (2 * (k - 1)));
  endfunction

endpackage

### src/bdsp_ram.sv
module bdsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/beamform_delay_sample_pick_top.sv
// Delay-and-sum sampler for one transducer element.
// Input channel: raise start with in_cmd and the fields; a word is taken at
// every rising edge where start is high and busy is low. busy stays low, so
// a new word may enter every cycle. in_cmd = write stores in_sample_value at
// in_sample_index; in_cmd = pixel forms the distance from (in_pixel_x,
// in_pixel_depth) to the element, adds the depth and looks up the trace.
// Result channel: out_valid is high for exactly one cycle per pixel word,
// with out_pixel_value, after the front, root, memory and output stages.
// Write words give no result. Throughput is one word per cycle: the
// 12-step root runs as 12 pipeline stages and the trace memory sees one
// access per cycle, in word order, at a single pipeline stage.
// Configuration: cfg_element_x is written when cfg_valid is high; cfg_ready
// is always high. Write it only while no word is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and clears element_x
// to zero; trace contents stay undefined until written. The receiver cannot
// stall, so results are never held back.
module beamform_delay_sample_pick_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_cmd,
  input  logic [bdsp_pkg::IDX_W-1:0]          in_sample_index,
  input  logic signed [bdsp_pkg::SMP_W-1:0]   in_sample_value,
  input  logic signed [bdsp_pkg::POS_W-1:0]   in_pixel_x,
  input  logic [bdsp_pkg::DEPTH_W-1:0]        in_pixel_depth,
  // Result channel
  output logic                                out_valid,
  output logic signed [bdsp_pkg::SMP_W-1:0]   out_pixel_value,
  // Configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic signed [bdsp_pkg::POS_W-1:0]   cfg_element_x
);

`include "assert_macros.svh"

  localparam int NSTG = bdsp_pkg::ROOT_STEPS;

  logic                                  accept;
  logic signed [bdsp_pkg::POS_W-1:0]     element_x_r;

  // Front stages
  logic                                  s0_vld_r;
  bdsp_pkg::item_t                       s0_item_r;
  logic signed [bdsp_pkg::DX_W-1:0]      dx_r;
  logic signed [2*bdsp_pkg::DX_W-1:0]    dx_prod;
  logic                                  s1_vld_r;
  bdsp_pkg::item_t                       s1_item_r;
  logic [bdsp_pkg::SQ_W-1:0]             dx2_r;
  logic [bdsp_pkg::SQ_W-1:0]             dd2_r;

  // Root stages: entry 0 holds the sum, entries 1..NSTG one root step each
  logic                                  rt_vld_r  [NSTG+1];
  bdsp_pkg::item_t                       rt_item_r [NSTG+1];
  logic [bdsp_pkg::REM_W-1:0]            rem_r     [NSTG+1];
  logic [bdsp_pkg::ROOT_W-1:0]           root_r    [NSTG+1];
  logic [bdsp_pkg::REM_W-1:0]            rem_nxt   [1:NSTG];
  logic [bdsp_pkg::ROOT_W-1:0]           root_nxt  [1:NSTG];

  // Memory stage
  logic [bdsp_pkg::SMP_W-1:0]            pos;
  logic                                  pos_in_rng;
  logic                                  ram_we;
  logic                                  ram_re;
  logic [bdsp_pkg::SMP_W-1:0]            ram_rdata;
  logic                                  rd_pend_r;
  logic                                  rng_r;

  // Output register
  logic                                  out_valid_r;
  logic signed [bdsp_pkg::SMP_W-1:0]     out_pixel_value_r;

  // Never stall either side
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Hold the element position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_x_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      element_x_r <= cfg_element_x;
    end
  end

  // Front stage valid bits and root stage valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      for (int i = 0; i <= NSTG; i++) begin
        rt_vld_r[i] <= 1'b0;
      end
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_vld_r    <= accept;
      s1_vld_r    <= s0_vld_r;
      rt_vld_r[0] <= s1_vld_r;
      for (int i = 1; i <= NSTG; i++) begin
        rt_vld_r[i] <= rt_vld_r[i-1];
      end
      rd_pend_r   <= rt_vld_r[NSTG] && (rt_item_r[NSTG].cmd == bdsp_pkg::CMD_PIXEL);
      out_valid_r <= rd_pend_r;
    end
  end

  // Capture the word and the lateral offset
  always_ff @(posedge clk) begin
    s0_item_r.cmd   <= in_cmd;
    s0_item_r.idx   <= in_sample_index;
    s0_item_r.val   <= in_sample_value;
    s0_item_r.depth <= in_pixel_depth;
    dx_r <= {in_pixel_x[bdsp_pkg::POS_W-1], in_pixel_x}
          - {element_x_r[bdsp_pkg::POS_W-1], element_x_r};
  end

  // Square both offsets
  assign dx_prod = (2*bdsp_pkg::DX_W)'(dx_r) * (2*bdsp_pkg::DX_W)'(dx_r);

  always_ff @(posedge clk) begin
    s1_item_r <= s0_item_r;
    dx2_r     <= dx_prod[bdsp_pkg::SQ_W-1:0];
    dd2_r     <= bdsp_pkg::SQ_W'(s0_item_r.depth) * bdsp_pkg::SQ_W'(s0_item_r.depth);
  end

  // Sum the squares, clear the root
  always_ff @(posedge clk) begin
    rt_item_r[0] <= s1_item_r;
    rem_r[0]     <= {1'b0, dx2_r} + {1'b0, dd2_r};
    root_r[0]    <= '0;
  end

  // One digit of the root per stage
  for (genvar k = 1; k <= NSTG; k++) begin : g_root
    localparam logic [bdsp_pkg::ROOT_W-1:0] BIT = bdsp_pkg::root_bit(k);
    logic [bdsp_pkg::REM_W:0] trial;
    logic                     take;

    always_comb begin
      trial = (bdsp_pkg::REM_W+1)'(root_r[k-1]) + (bdsp_pkg::REM_W+1)'(BIT);
      take  = {1'b0, rem_r[k-1]} >= trial;
      if (take) begin
        rem_nxt[k]  = rem_r[k-1] - trial[bdsp_pkg::REM_W-1:0];
        root_nxt[k] = (root_r[k-1] >> 1) + BIT;
      end else begin
        rem_nxt[k]  = rem_r[k-1];
        root_nxt[k] = root_r[k-1] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      rt_item_r[k] <= rt_item_r[k-1];
      rem_r[k]     <= rem_nxt[k];
      root_r[k]    <= root_nxt[k];
    end
  end

  // Form the sample position and check it against the trace
  assign pos = root_r[NSTG][bdsp_pkg::SMP_W-1:0]
             + bdsp_pkg::SMP_W'(rt_item_r[NSTG].depth);
  assign pos_in_rng = !pos[bdsp_pkg::SMP_W-1]
                   && ({1'b0, pos} < (bdsp_pkg::SMP_W+1)'(bdsp_pkg::TRACE_LEN));

  // Access the trace in word order: write or read, one per cycle
  assign ram_we = rt_vld_r[NSTG] && (rt_item_r[NSTG].cmd == bdsp_pkg::CMD_WRITE)
               && ((bdsp_pkg::SMP_W+1)'(rt_item_r[NSTG].idx)
                   < (bdsp_pkg::SMP_W+1)'(bdsp_pkg::TRACE_LEN));
  assign ram_re = rt_vld_r[NSTG] && (rt_item_r[NSTG].cmd == bdsp_pkg::CMD_PIXEL)
               && pos_in_rng;

  bdsp_ram #(
    .WIDTH (bdsp_pkg::SMP_W),
    .DEPTH (bdsp_pkg::TRACE_LEN)
  ) u_trace (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rt_item_r[NSTG].idx[bdsp_pkg::ADDR_W-1:0]),
    .wdata (rt_item_r[NSTG].val),
    .re    (ram_re),
    .raddr (pos[bdsp_pkg::ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    rng_r <= pos_in_rng;
  end

  // Register the result, zero when outside the trace
  always_ff @(posedge clk) begin
    out_pixel_value_r <= rng_r ? $signed(ram_rdata) : '0;
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pixel_value_r;

  // Checks
  `ASSERT_SAME(a_one_access, clk, rst_n, ram_we, !ram_re)
  `ASSERT_NEXT(a_pixel_gives_result, clk, rst_n, rd_pend_r, out_valid)
  `ASSERT_NEXT(a_outside_is_zero, clk, rst_n, rd_pend_r && !rng_r, out_pixel_value == '0)
  `ASSERT_SAME(a_result_from_pixel, clk, rst_n, out_valid,
               $past(accept && (in_cmd == bdsp_pkg::CMD_PIXEL), 17))

endmodule

### bench/bdsp_pixel_checker.sv
`timescale 1ns / 100ps

package pick_delay_pkg;
  import bdsp_pkg::*;

  // Trace position a pixel reads: depth plus the fixed-step root of the squared distance
  function automatic int echo_delay_pos(input logic signed [POS_W-1:0] px,
                                        input logic signed [POS_W-1:0] ex,
                                        input logic [DEPTH_W-1:0] depth);
    longint dx;
    longint dist_sq;
    longint trial;
    longint root;
    logic signed [SMP_W-1:0] pos16;
    dx      = longint'(px) - longint'(ex);
    dist_sq = dx * dx + longint'(depth) * longint'(depth);
    trial   = ROOT_START_BIT;
    root    = 0;
    // Lower the trial bit below the remainder, a fixed number of times
    for (int i = 0; i < ROOT_STEPS; i++) begin
      if (trial > dist_sq) trial = trial >>> 2;
    end
    // Digit-by-digit steps; sums above 2^24 keep whatever these steps give
    for (int i = 0; i < ROOT_STEPS; i++) begin
      if (trial != 0) begin
        if (dist_sq >= root + trial) begin
          dist_sq = dist_sq - (root + trial);
          root    = (root + 2 * trial) >>> 1;
        end else begin
          root = root >>> 1;
        end
        trial = trial >>> 2;
      end
    end
    // Root and index both wrap to a signed 16-bit value
    pos16 = SMP_W'(root + longint'(depth));
    return int'(pos16);
  endfunction

endpackage

module bdsp_pixel_checker
  import bdsp_pkg::*;
  import pick_delay_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       in_cmd,
  input  logic [IDX_W-1:0]           in_sample_index,
  input  logic signed [SMP_W-1:0]    in_sample_value,
  input  logic signed [POS_W-1:0]    in_pixel_x,
  input  logic [DEPTH_W-1:0]         in_pixel_depth,
  input  logic                       out_valid,
  input  logic signed [SMP_W-1:0]    out_pixel_value,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic signed [POS_W-1:0]    cfg_element_x,
  output int                         mismatch_count,
  output int                         pixels_pending
);

  logic signed [SMP_W-1:0] trace_copy [TRACE_LEN];
  logic signed [POS_W-1:0] element_copy;
  logic signed [SMP_W-1:0] expected_pixels [$];

  initial begin
    mismatch_count = 0;
    pixels_pending = 0;
    element_copy   = '0;
  end

  always @(posedge clk) begin : watch
    int                      pos;
    logic signed [SMP_W-1:0] want;
    if (!rst_n) begin
      element_copy = '0;
      expected_pixels.delete();
    end else begin
      // Retire the oldest expected pixel word
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: pixel_value expected none, got %0d", $time, out_pixel_value);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_value !== want) begin
            $display("%0t: pixel_value expected %0d, got %0d", $time, want, out_pixel_value);
            mismatch_count++;
          end
        end
      end
      // Track the element position
      if (cfg_valid && cfg_ready) element_copy = cfg_element_x;
      // Apply writes in word order; look pixels up at acceptance
      if (start && !busy) begin
        if (in_cmd == CMD_WRITE) begin
          trace_copy[in_sample_index] = in_sample_value;
        end else begin
          pos = echo_delay_pos(in_pixel_x, element_copy, in_pixel_depth);
          if (pos >= 0 && pos < TRACE_LEN) begin
            expected_pixels.push_back(trace_copy[pos[ADDR_W-1:0]]);
          end else begin
            expected_pixels.push_back('0);
          end
        end
      end
    end
    pixels_pending = expected_pixels.size();
  end

endmodule

### bench/beamform_delay_sample_pick_top_tb.sv
`timescale 1ns / 100ps

module beamform_delay_sample_pick_top_tb;
  import bdsp_pkg::*;
  import pick_delay_pkg::*;

  localparam int PHASE_WORDS  = 240;
  localparam int PHASES       = 6;
  localparam int DRAIN_CYCLES = 24;
  localparam int STALL_LIMIT  = 2000;
  localparam int X_MIN        = -2048;
  localparam int X_MAX        = 2047;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_cmd;
  logic [IDX_W-1:0]         in_sample_index;
  logic signed [SMP_W-1:0]  in_sample_value;
  logic signed [POS_W-1:0]  in_pixel_x;
  logic [DEPTH_W-1:0]       in_pixel_depth;
  logic                     out_valid;
  logic signed [SMP_W-1:0]  out_pixel_value;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic signed [POS_W-1:0]  cfg_element_x;

  int                       mismatch_count;
  int                       pixels_pending;
  int                       idle_cycles = 0;
  int                       burst_left = 0;
  int                       phase_words = 0;
  logic signed [POS_W-1:0]  element_now = '0;
  bit                       written_entry [TRACE_LEN];

  beamform_delay_sample_pick_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_sample_index (in_sample_index),
    .in_sample_value (in_sample_value),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_depth  (in_pixel_depth),
    .out_valid       (out_valid),
    .out_pixel_value (out_pixel_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_element_x   (cfg_element_x)
  );

  bdsp_pixel_checker pixel_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_sample_index (in_sample_index),
    .in_sample_value (in_sample_value),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_depth  (in_pixel_depth),
    .out_valid       (out_valid),
    .out_pixel_value (out_pixel_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_element_x   (cfg_element_x),
    .mismatch_count  (mismatch_count),
    .pixels_pending  (pixels_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // End the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold start low while the fields carry noise
  task automatic idle_noise(input int cycles);
    start <= 1'b0;
    repeat (cycles) begin
      in_cmd          <= 1'($urandom);
      in_sample_index <= IDX_W'($urandom);
      in_sample_value <= SMP_W'($urandom);
      in_pixel_x      <= POS_W'($urandom);
      in_pixel_depth  <= DEPTH_W'($urandom);
      @(negedge clk);
    end
  endtask

  // Send in bursts of random length, with random gaps between them
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) idle_noise($urandom_range(1, 8));
    end
    burst_left--;
  endtask

  task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic signed [SMP_W-1:0] val,
                           input logic signed [POS_W-1:0] px,
                           input logic [DEPTH_W-1:0] depth);
    pace();
    start           <= 1'b1;
    in_cmd          <= cmd;
    in_sample_index <= idx;
    in_sample_value <= val;
    in_pixel_x      <= px;
    in_pixel_depth  <= depth;
    do @(posedge clk); while (busy);
    @(negedge clk);
    phase_words++;
  endtask

  task automatic send_sample(input logic [IDX_W-1:0] idx, input logic signed [SMP_W-1:0] val);
    send_word(CMD_WRITE, idx, val, POS_W'($urandom), DEPTH_W'($urandom));
    written_entry[idx] = 1'b1;
  endtask

  // Write the entry a pixel will read first when it is unwritten, sometimes anyway
  task automatic send_pixel(input logic signed [POS_W-1:0] px, input logic [DEPTH_W-1:0] depth);
    int pos;
    pos = echo_delay_pos(px, element_now, depth);
    if (pos >= 0 && pos < TRACE_LEN &&
        (!written_entry[pos] || $urandom_range(0, 3) == 0)) begin
      send_sample(IDX_W'(pos), SMP_W'($urandom));
    end
    send_word(CMD_PIXEL, IDX_W'($urandom), SMP_W'($urandom), px, depth);
  endtask

  task automatic random_pixel();
    int choice;
    int lateral;
    choice = $urandom_range(0, 9);
    if (choice < 3) begin
      send_pixel(POS_W'($urandom), DEPTH_W'($urandom));
    end else if (choice == 3) begin
      send_pixel($urandom_range(0, 1) ? POS_W'(X_MAX) : POS_W'(X_MIN),
                 $urandom_range(0, 1) ? DEPTH_W'(TRACE_LEN - 1) : DEPTH_W'(0));
    end else begin
      // Stay near the element so most delays land inside the trace
      lateral = int'($urandom_range(0, 3000)) - 1500 + int'(element_now);
      if (lateral < X_MIN) lateral = X_MIN;
      if (lateral > X_MAX) lateral = X_MAX;
      send_pixel(POS_W'(lateral), DEPTH_W'($urandom_range(0, 1800)));
    end
  endtask

  // Wait for the last result, then for any write still in flight
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (pixels_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_element(input logic signed [POS_W-1:0] ex);
    wait_drained();
    cfg_valid     <= 1'b1;
    cfg_element_x <= ex;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid   <= 1'b0;
    element_now = ex;
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_cmd          = CMD_WRITE;
    in_sample_index = '0;
    in_sample_value = '0;
    in_pixel_x      = '0;
    in_pixel_depth  = '0;
    cfg_valid       = 1'b0;
    cfg_element_x   = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words with the element at its reset position
    send_sample(IDX_W'(0), SMP_W'(-32768));
    send_sample(IDX_W'(TRACE_LEN - 1), SMP_W'(32767));
    send_sample(12'h555, 16'h5555);
    send_sample(12'hAAA, 16'hAAAA);
    send_pixel(POS_W'(0), DEPTH_W'(0));
    send_pixel(POS_W'(1), DEPTH_W'(0));
    send_pixel(POS_W'(X_MIN), DEPTH_W'(0));
    send_pixel(POS_W'(0), DEPTH_W'(2047));
    // delay just past the trace end
    send_pixel(POS_W'(0), DEPTH_W'(2048));
    // squared distance above 2^24
    send_pixel(POS_W'(X_MAX), DEPTH_W'(TRACE_LEN - 1));
    send_pixel(POS_W'(X_MIN), DEPTH_W'(TRACE_LEN - 1));
    // overwrite an entry right before reading it
    send_sample(IDX_W'(9), 16'h1234);
    send_pixel(POS_W'(3), DEPTH_W'(4));
    send_sample(IDX_W'(9), 16'hEDCB);
    send_pixel(POS_W'(3), DEPTH_W'(4));
    send_pixel(POS_W'(-3), DEPTH_W'(4));

    // Random phases, each under its own element position
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: ;
        1: set_element(POS_W'(X_MIN));
        2: set_element(POS_W'(X_MAX));
        PHASES - 1: set_element('0);
        default: set_element(POS_W'($urandom));
      endcase
      phase_words = 0;
      send_pixel(POS_W'(X_MIN), DEPTH_W'(0));
      send_pixel(POS_W'(X_MAX), DEPTH_W'(0));
      send_pixel(POS_W'(X_MAX), DEPTH_W'(TRACE_LEN - 1));
      while (phase_words < PHASE_WORDS) begin
        if ($urandom_range(0, 99) < 30) begin
          send_sample(IDX_W'($urandom), SMP_W'($urandom));
        end else begin
          random_pixel();
        end
      end
    end

    wait_drained();
    if (mismatch_count == 0 && pixels_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### beamform_delay_sample_pick_top.f
+incdir+src
src/bdsp_pkg.sv
src/bdsp_ram.sv
src/beamform_delay_sample_pick_top.sv
bench/bdsp_pixel_checker.sv
bench/beamform_delay_sample_pick_top_tb.sv
